FILE: sv/mhtq_pkg.sv
// mhtq_pkg: shared types and constants for the timer queue
// no dependencies; imported by mhtq_ram users and min_heap_timer_queue
`default_nettype none

package mhtq_pkg;

    // field widths
    localparam int OP_W       = 3;
    localparam int ID_W       = 10;
    localparam int TO_W       = 24;
    localparam int TIME_W     = 48;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 2;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;

    // at most this many ids expire in one request
    localparam int EXP_MAX = 32;
    localparam int DONE_W  = 6;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADJUST = 3'd1;
    localparam logic [OP_W-1:0] OP_POP    = 3'd2;
    localparam logic [OP_W-1:0] OP_EXPIRE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;
    localparam logic [ERR_W-1:0] ERR_EMPTY   = 2'd3;

    // one heap slot: owner id above the deadline
    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] dl;
    } t_hent;

    localparam int HENT_W = ID_W + TIME_W;

endpackage

`default_nettype wire

FILE: sv/mhtq_ram.sv
// mhtq_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mhtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/min_heap_timer_queue.sv
// min_heap_timer_queue: timer queue as a binary min-heap of deadlines
// depends on mhtq_pkg and mhtq_ram (heap slots and id-to-slot table)
//
//  channel | dir | tdata (low bit up)                         | tuser  | tlast
//  s_axis  | in  | entry_id, timeout_ms, now_ms               | opcode | -
//  m_axis  | out | out_id, wait_ms, queue_empty, error_code   | kind   | last
//
// one request at a time; lookup (S_DISP, S_LOOK1, S_LOOK2; for pop S_DISP,
// S_POP1, S_RM, S_RM_LAST) precedes the heap walk, after which the walk
// closes and S_EMIT issues the result. a level down passes S_SD_L, S_SD_R,
// S_SD_RCK (skipped where only a left child exists) and S_SD_CMP, a level up
// S_SU and S_SU_CK, each bound by the one read port of the heap ram. expire
// first scans the heap (up to 32 entries), then removes one per tree walk.
// reset needs no clearing pass: a table entry counts only when the slot it
// names is in use and owned by that id. a full output register stalls the
// walk only where a result is issued.
`default_nettype none

module min_heap_timer_queue
    import mhtq_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int ID_SPACE = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // entry_id, timeout_ms, now_ms
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode
    input  wire logic [OP_W-1:0]        i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // out_id, wait_ms, queue_empty, error_code
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // kind
    output logic [KIND_W-1:0]           o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ID_AW  = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
    localparam int IDX_W  = (ID_AW > ID_W) ? ID_AW : ID_W;
    localparam int IX_W   = SLOT_W + 2;
    localparam int CC_W   = ((CNT_W > DONE_W) ? CNT_W : DONE_W) + 1;

    // states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_LOOK1   = 5'd2;
    localparam logic [4:0] S_LOOK2   = 5'd3;
    localparam logic [4:0] S_POP1    = 5'd4;
    localparam logic [4:0] S_RM      = 5'd5;
    localparam logic [4:0] S_RM_LAST = 5'd6;
    localparam logic [4:0] S_SD_L    = 5'd7;
    localparam logic [4:0] S_SD_R    = 5'd8;
    localparam logic [4:0] S_SD_RCK  = 5'd9;
    localparam logic [4:0] S_SD_CMP  = 5'd10;
    localparam logic [4:0] S_SD_END  = 5'd11;
    localparam logic [4:0] S_SU      = 5'd12;
    localparam logic [4:0] S_SU_CK   = 5'd13;
    localparam logic [4:0] S_EXP_RD  = 5'd14;
    localparam logic [4:0] S_EXP_CK  = 5'd15;
    localparam logic [4:0] S_SCAN_RD = 5'd16;
    localparam logic [4:0] S_SCAN_CK = 5'd17;
    localparam logic [4:0] S_EMIT    = 5'd18;

    // id to table address
    function automatic logic [ID_AW-1:0] f_ida(input logic [ID_W-1:0] id);
        logic [IDX_W-1:0] e;
        e = IDX_W'(id);
        return e[ID_AW-1:0];
    endfunction

    // control and request registers
    logic [4:0]        r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [TIME_W-1:0] r_dl, n_dl;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic              r_moved, n_moved;
    t_hent             r_node, n_node;
    t_hent             r_ch, n_ch;
    logic [SLOT_W-1:0] r_ci, n_ci;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [DONE_W-1:0] r_done, n_done;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_allok, n_allok;
    logic              r_fin_empty, n_fin_empty;

    // staged result
    logic [KIND_W-1:0] r_rk, n_rk;
    logic [ID_W-1:0]   r_rid, n_rid;
    logic [TO_W-1:0]   r_rw, n_rw;
    logic [ERR_W-1:0]  r_re, n_re;
    logic              r_rl, n_rl;

    // output register
    logic              r_ovalid;
    logic [KIND_W-1:0] r_okind;
    logic [ID_W-1:0]   r_oid;
    logic [TO_W-1:0]   r_owait;
    logic              r_oempty;
    logic [ERR_W-1:0]  r_oerr;
    logic              r_olast;

    // ram ports
    logic              h_we;
    logic [SLOT_W-1:0] h_wa, h_ra;
    t_hent             h_wd;
    logic [HENT_W-1:0] h_rdv;
    t_hent             h_rd;
    logic              t_we;
    logic [ID_AW-1:0]  t_wa, t_ra;
    logic [SLOT_W-1:0] t_wd, t_rd;

    // helpers
    logic              w_accept, w_ofree, w_emit, w_id_ok, w_found, w_qe;
    logic [TIME_W:0]   w_sum;
    logic [IX_W-1:0]   w_c, w_cr, w_cnt_x;
    logic [SLOT_W-1:0] w_p;
    logic [4:0]        w_after;
    logic [TIME_W-1:0] w_diff;
    logic              w_due;

    mhtq_ram #(.WIDTH(HENT_W), .DEPTH(CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_wa),
        .i_wdata (h_wd),
        .i_raddr (h_ra),
        .o_rdata (h_rdv)
    );

    mhtq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_slot_tbl (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_wa),
        .i_wdata (t_wd),
        .i_raddr (t_ra),
        .o_rdata (t_rd)
    );

    assign h_rd = t_hent'(h_rdv);

    // handshake and shared arithmetic
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ofree  = !r_ovalid || i_m_axis_tready;
    assign w_emit   = (r_state == S_EMIT) && w_ofree;
    assign w_sum    = {1'b0, i_s_axis_tdata[81:34]} + (TIME_W+1)'(i_s_axis_tdata[33:10]);
    assign w_id_ok  = {1'b0, IDX_W'(r_id)} < (IDX_W+1)'(ID_SPACE);
    assign w_c      = {1'b0, r_pos, 1'b1};
    assign w_cr     = w_c + IX_W'(1);
    assign w_cnt_x  = IX_W'(r_count);
    assign w_p      = (r_pos - SLOT_W'(1)) >> 1;
    assign w_found  = (IX_W'(r_slot) < w_cnt_x) && (h_rd.owner == r_id);
    assign w_after  = (r_op == OP_EXPIRE) ? S_EXP_RD : S_EMIT;
    assign w_diff   = h_rd.dl - r_now;
    assign w_due    = h_rd.dl <= r_now;
    assign w_qe     = (r_op == OP_EXPIRE) ? r_fin_empty : (r_count == '0);

    // sequencer: lookup, heap walk and result staging
    always_comb begin
        n_state = r_state;   n_op = r_op;       n_id = r_id;
        n_dl = r_dl;         n_now = r_now;     n_count = r_count;
        n_pos = r_pos;       n_moved = r_moved; n_node = r_node;
        n_ch = r_ch;         n_ci = r_ci;       n_slot = r_slot;
        n_done = r_done;     n_idx = r_idx;     n_allok = r_allok;
        n_fin_empty = r_fin_empty;
        n_rk = r_rk; n_rid = r_rid; n_rw = r_rw; n_re = r_re; n_rl = r_rl;
        h_we = 1'b0; h_wa = r_pos; h_wd = r_node; h_ra = '0;
        t_we = 1'b0; t_wa = f_ida(r_node.owner); t_wd = r_pos; t_ra = f_ida(r_id);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_s_axis_tuser;
                    n_id    = i_s_axis_tdata[9:0];
                    n_now   = i_s_axis_tdata[81:34];
                    n_dl    = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_rk = KIND_ACK; n_rid = '0; n_rw = '0; n_re = ERR_NONE; n_rl = 1'b1;
                n_state = S_EMIT;
                priority if (r_op == OP_ADD || r_op == OP_ADJUST) begin
                    if (!w_id_ok) begin
                        n_rk = KIND_ERROR; n_re = ERR_UNKNOWN;
                    end else begin
                        n_state = S_LOOK1;
                    end
                end else if (r_op == OP_POP) begin
                    if (r_count == '0) begin
                        n_rk = KIND_ERROR; n_re = ERR_EMPTY;
                    end else begin
                        n_state = S_POP1;
                    end
                end else if (r_op == OP_EXPIRE) begin
                    n_done = '0;
                    n_idx = '0;
                    n_allok = 1'b1;
                    priority if (r_count == '0) begin
                        n_fin_empty = 1'b1;
                        n_state = S_EXP_RD;
                    end else if (CC_W'(r_count) <= CC_W'(EXP_MAX)) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_fin_empty = 1'b0;
                        n_state = S_EXP_RD;
                    end
                end else if (r_op == OP_CLEAR) begin
                    n_count = '0;
                end else begin
                    n_count = r_count;
                end
            end
            // slot of the id, then owner check of that slot
            S_LOOK1: begin
                n_slot = t_rd;
                h_ra = t_rd;
                n_state = S_LOOK2;
            end
            S_LOOK2: begin
                n_node = '{owner: r_id, dl: r_dl};
                n_moved = 1'b0;
                priority if (w_found) begin
                    n_pos = r_slot;
                    n_state = S_SD_L;
                end else if (r_op == OP_ADJUST) begin
                    n_rk = KIND_ERROR; n_re = ERR_UNKNOWN;
                    n_state = S_EMIT;
                end else if (r_count >= CNT_W'(CAPACITY)) begin
                    n_rk = KIND_ERROR; n_re = ERR_FULL;
                    n_state = S_EMIT;
                end else begin
                    n_pos = r_count[SLOT_W-1:0];
                    n_count = r_count + CNT_W'(1);
                    n_state = S_SU;
                end
            end
            S_POP1: begin
                h_ra = '0;
                n_rid = h_rd.owner;
                n_state = S_RM;
            end
            // remove the root: last slot moves to the top and sinks
            S_RM: begin
                n_count = r_count - CNT_W'(1);
                h_ra = SLOT_W'(r_count - CNT_W'(1));
                n_state = (r_count == CNT_W'(1)) ? w_after : S_RM_LAST;
            end
            S_RM_LAST: begin
                n_node = h_rd;
                n_pos = '0;
                n_moved = 1'b0;
                n_state = S_SD_L;
            end
            // sift down: left child, right child, pick, compare
            S_SD_L: begin
                if (w_c < w_cnt_x) begin
                    h_ra = w_c[SLOT_W-1:0];
                    n_ci = w_c[SLOT_W-1:0];
                    n_state = S_SD_R;
                end else begin
                    n_state = S_SD_END;
                end
            end
            S_SD_R: begin
                n_ch = h_rd;
                if (w_cr < w_cnt_x) begin
                    h_ra = w_cr[SLOT_W-1:0];
                    n_state = S_SD_RCK;
                end else begin
                    n_state = S_SD_CMP;
                end
            end
            S_SD_RCK: begin
                if (h_rd.dl < r_ch.dl) begin
                    n_ch = h_rd;
                    n_ci = w_cr[SLOT_W-1:0];
                end
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                if (r_node.dl < r_ch.dl) begin
                    n_state = S_SD_END;
                end else begin
                    h_we = 1'b1; h_wd = r_ch;
                    t_we = 1'b1; t_wa = f_ida(r_ch.owner);
                    n_pos = r_ci;
                    n_moved = 1'b1;
                    n_state = S_SD_L;
                end
            end
            S_SD_END: begin
                if (r_moved) begin
                    h_we = 1'b1; t_we = 1'b1;
                    n_state = w_after;
                end else begin
                    n_state = S_SU;
                end
            end
            // sift up: parent moves down until it is strictly earlier
            S_SU: begin
                if (r_pos == '0) begin
                    h_we = 1'b1; t_we = 1'b1;
                    n_state = w_after;
                end else begin
                    h_ra = w_p;
                    n_state = S_SU_CK;
                end
            end
            S_SU_CK: begin
                if (h_rd.dl < r_node.dl) begin
                    h_we = 1'b1; t_we = 1'b1;
                    n_state = w_after;
                end else begin
                    h_we = 1'b1; h_wd = h_rd;
                    t_we = 1'b1; t_wa = f_ida(h_rd.owner);
                    n_pos = w_p;
                    n_state = S_SU;
                end
            end
            // expire: look at the root, expire it or report the wait
            S_EXP_RD: begin
                h_ra = '0;
                if (r_count == '0) begin
                    n_rk = KIND_WAIT; n_rid = '0; n_rw = '0; n_re = ERR_NONE; n_rl = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_EXP_CK;
                end
            end
            S_EXP_CK: begin
                n_rid = '0; n_rw = '0; n_re = ERR_NONE;
                n_state = S_EMIT;
                if (w_due && (r_done < DONE_W'(EXP_MAX))) begin
                    n_rk = KIND_EXPIRED; n_rid = h_rd.owner; n_rl = 1'b0;
                    n_done = r_done + DONE_W'(1);
                end else begin
                    n_rk = KIND_WAIT; n_rl = 1'b1;
                    if (!w_due) begin
                        n_rw = (w_diff[TIME_W-1:TO_W] != '0) ? '1 : w_diff[TO_W-1:0];
                    end
                end
            end
            // pre-scan: the queue ends empty only if every entry is due
            S_SCAN_RD: begin
                h_ra = r_idx;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                n_allok = r_allok && w_due;
                if (CNT_W'(r_idx) == r_count - CNT_W'(1)) begin
                    n_fin_empty = r_allok && w_due;
                    n_state = S_EXP_RD;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_EMIT: begin
                if (w_ofree) begin
                    n_state = r_rl ? S_IDLE : S_RM;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op;     r_id <= n_id;       r_dl <= n_dl;     r_now <= n_now;
        r_pos <= n_pos;   r_moved <= n_moved; r_node <= n_node; r_ch <= n_ch;
        r_ci <= n_ci;     r_slot <= n_slot;   r_done <= n_done; r_idx <= n_idx;
        r_allok <= n_allok;
        r_fin_empty <= n_fin_empty;
        r_rk <= n_rk; r_rid <= n_rid; r_rw <= n_rw; r_re <= n_re; r_rl <= n_rl;
        if (w_emit) begin
            r_okind  <= r_rk;
            r_oid    <= r_rid;
            r_owait  <= r_rw;
            r_oempty <= w_qe;
            r_oerr   <= r_re;
            r_olast  <= r_rl;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {3'b000, r_oerr, r_oempty, r_owait, r_oid};
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

    // checks
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_pos_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SD_L || r_state == S_SU) |-> (IX_W'(r_pos) < w_cnt_x))
        else $error("sift position outside the heap");

    a_expired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_EXPIRED) |-> !o_m_axis_tlast)
        else $error("expired id marked as final result");

    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser == KIND_ERROR) == (r_oerr != ERR_NONE)))
        else $error("error code and kind disagree");

endmodule

`default_nettype wire
